// ----- hdl/bellman_ford_shortest_paths_macros.svh -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_macros.svh
// assertion shorthands for the shortest path block checkers
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH

// same cycle implication, sampled on clk, quiet in reset
`define BFSP_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfsp check failed");

// next cycle implication, sampled on clk, quiet in reset
`define BFSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfsp check failed");

`endif

// ----- hdl/bfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsp_pkg
// shared constants, request codes and edge store command type
// ----------------------------------------------------------------------------
`default_nettype none

package bfsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int NCOUNT_W  = NODE_W + 1;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int COST_W    = 16;
    localparam int DIST_W    = 32;
    localparam int EDGE_W    = COST_W + 1;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // command from the sequencer to the edge store
    typedef struct packed {
        logic                     add;
        logic                     clr;
        logic [ADDR_W-1:0]        addr;
        logic signed [COST_W-1:0] cost;
    } edge_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/bfsp_if.sv -----
// ----------------------------------------------------------------------------
// bfsp_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bfsp_req_if;
    import bfsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [NODE_W-1:0]        src_node;
    logic [NODE_W-1:0]        dst_node;
    logic signed [COST_W-1:0] edge_cost;

    modport source (output valid, req_type, src_node, dst_node, edge_cost, input ready);
    modport sink   (input valid, req_type, src_node, dst_node, edge_cost, output ready);
endinterface

interface bfsp_res_if;
    import bfsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NODE_W-1:0]        node_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last;

    modport source (output valid, node_index, distance, reachable, negative_cycle, last,
                    input ready);
    modport sink   (input valid, node_index, distance, reachable, negative_cycle, last,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/bfsp_ram.sv -----
// ----------------------------------------------------------------------------
// bfsp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, read returns the old word on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/bfsp_edge_store.sv -----
// ----------------------------------------------------------------------------
// bfsp_edge_store
// adjacency matrix of present flag and cost, min-merge on add, clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module bfsp_edge_store (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bfsp_pkg::edge_cmd_t               cmd,
    input  wire logic [bfsp_pkg::ADDR_W-1:0]       rd_addr,
    output logic                                   busy,
    output logic                                   rd_present,
    output logic signed [bfsp_pkg::COST_W-1:0]     rd_weight
);
    import bfsp_pkg::*;

    logic                     p_valid_reg;
    logic [ADDR_W-1:0]        p_addr_reg;
    logic signed [COST_W-1:0] p_cost_reg;
    logic                     fw_valid_reg;
    logic [ADDR_W-1:0]        fw_addr_reg;
    logic [EDGE_W-1:0]        fw_word_reg;
    logic                     busy_reg;
    logic                     busy_next;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [ADDR_W-1:0]        clr_cnt_next;

    logic [EDGE_W-1:0]        ram_rdata;
    logic [EDGE_W-1:0]        old_word;
    logic [EDGE_W-1:0]        new_word;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [EDGE_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;

    bfsp_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_NODES * MAX_NODES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // add reads at the new pair, otherwise the sequencer address
    assign ram_raddr = cmd.add ? cmd.addr : rd_addr;

    // forward the word written last cycle to a back-to-back add of the same pair
    always_comb
    begin
        if (fw_valid_reg && (fw_addr_reg == p_addr_reg))
        begin
            old_word = fw_word_reg;
        end
        else
        begin
            old_word = ram_rdata;
        end
        if (!old_word[COST_W] || (p_cost_reg < $signed(old_word[COST_W-1:0])))
        begin
            new_word = {1'b1, p_cost_reg};
        end
        else
        begin
            new_word = old_word;
        end
    end

    // write port: pending merge first, clearing sweep otherwise
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = clr_cnt_reg;
        ram_wdata    = '0;
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (p_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = p_addr_reg;
            ram_wdata = new_word;
        end
        else if (busy_reg)
        begin
            ram_we       = 1'b1;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {ADDR_W{1'b1}})
            begin
                busy_next = 1'b0;
            end
        end
        if (cmd.clr)
        begin
            busy_next    = 1'b1;
            clr_cnt_next = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            fw_valid_reg <= 1'b0;
            busy_reg     <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            p_valid_reg  <= cmd.add;
            fw_valid_reg <= p_valid_reg;
            busy_reg     <= busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // merge stage payload
    always_ff @(posedge clk)
    begin
        p_addr_reg  <= cmd.addr;
        p_cost_reg  <= cmd.cost;
        fw_addr_reg <= p_addr_reg;
        fw_word_reg <= new_word;
    end

    assign busy       = busy_reg;
    assign rd_present = ram_rdata[COST_W];
    assign rd_weight  = $signed(ram_rdata[COST_W-1:0]);

endmodule

`default_nettype wire

// ----- hdl/bellman_ford_shortest_paths.sv -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// add edge: one word per cycle, back to back while idle; clear: a sweep of the
// whole matrix; run over n nodes: (n+1) passes over the reached rows, then one
// distance word per node past node zero, or one lone negative cycle word
// reset: control cleared at once, then a sweep over all 4096 pairs empties the matrix
// ----------------------------------------------------------------------------
`default_nettype none

module bellman_ford_shortest_paths (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bfsp_req_if.sink                               req,
    bfsp_res_if.source                             res,
    input  wire logic                              cfg_we,
    input  wire logic [bfsp_pkg::NCOUNT_W-1:0]     cfg_wdata
);
    import bfsp_pkg::*;

    typedef enum logic [10:0] {
        S_CLR       = 11'b000_0000_0001,
        S_IDLE      = 11'b000_0000_0010,
        S_INIT      = 11'b000_0000_0100,
        S_ROW       = 11'b000_0000_1000,
        S_ROWLD     = 11'b000_0001_0000,
        S_RD        = 11'b000_0010_0000,
        S_ADD       = 11'b000_0100_0000,
        S_CMP       = 11'b000_1000_0000,
        S_FLAG      = 11'b001_0000_0000,
        S_EMIT_RD   = 11'b010_0000_0000,
        S_EMIT_WAIT = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic                     low;
        logic signed [DIST_W-1:0] value;
    } sat_t;

    // saturating distance plus cost, flags a clip at the lower bound
    function automatic sat_t sat_add(input logic signed [DIST_W-1:0] d,
                                     input logic signed [COST_W-1:0] w);
        logic signed [DIST_W:0] sum;
        sat_t                   r;
        sum = $signed({d[DIST_W-1], d})
            + $signed({{(DIST_W+1-COST_W){w[COST_W-1]}}, w});
        r.low = 1'b0;
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            if (sum[DIST_W])
            begin
                r.low   = 1'b1;
                r.value = $signed({1'b1, {(DIST_W-1){1'b0}}});
            end
            else
            begin
                r.value = $signed({1'b0, {(DIST_W-1){1'b1}}});
            end
        end
        else
        begin
            r.value = sum[DIST_W-1:0];
        end
        return r;
    endfunction

    state_t                   state_reg, state_next;
    logic [NCOUNT_W-1:0]      ncount_reg;
    logic [NCOUNT_W-1:0]      n_eff;
    logic [NODE_W-1:0]        n_last;
    logic [NODE_W-1:0]        s_reg, s_next;
    logic [NODE_W-1:0]        e_reg, e_next;
    logic [NODE_W-1:0]        i_reg, i_next;
    logic [NCOUNT_W-1:0]      round_reg, round_next;
    logic [MAX_NODES-1:0]     reached_reg, reached_next;
    logic                     low_reg, low_next;
    logic                     found_reg, found_next;
    logic signed [DIST_W-1:0] ds_reg, ds_next;
    logic signed [DIST_W-1:0] de_reg;
    logic signed [DIST_W-1:0] cand_reg;
    logic                     pres_reg;
    sat_t                     sum_now;

    logic                     out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]        out_index_reg, out_index_next;
    logic signed [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic                     out_reach_reg, out_reach_next;
    logic                     out_cycle_reg, out_cycle_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_free;

    edge_cmd_t                cmd;
    logic                     edge_busy;
    logic                     edge_present;
    logic signed [COST_W-1:0] edge_weight;
    logic                     accept;

    logic                     dist_we;
    logic [NODE_W-1:0]        dist_waddr;
    logic signed [DIST_W-1:0] dist_wdata;
    logic [NODE_W-1:0]        dist_raddr;
    logic [DIST_W-1:0]        dist_rdata;

    bfsp_edge_store u_edge_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_addr    ({s_reg, e_reg}),
        .busy       (edge_busy),
        .rd_present (edge_present),
        .rd_weight  (edge_weight)
    );

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // effective node count, clipped to 1..MAX_NODES
    always_comb
    begin
        if (ncount_reg == '0)
        begin
            n_eff = NCOUNT_W'(1);
        end
        else if (ncount_reg > NCOUNT_W'(MAX_NODES))
        begin
            n_eff = NCOUNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = ncount_reg;
        end
    end
    assign n_last = NODE_W'(n_eff - 1'b1);

    // handshake and edge store commands
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cmd.add   = accept && (req.req_type == REQ_ADD);
    assign cmd.clr   = accept && (req.req_type == REQ_CLEAR);
    assign cmd.addr  = {req.src_node, req.dst_node};
    assign cmd.cost  = req.edge_cost;

    assign out_free  = !out_valid_reg || res.ready;
    assign sum_now   = sat_add(ds_reg, edge_weight);

    // distance ram read address
    always_comb
    begin
        unique case (state_reg)
            S_RD:                   dist_raddr = e_reg;
            S_EMIT_RD, S_EMIT_WAIT: dist_raddr = i_reg;
            default:                dist_raddr = s_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        logic improve;
        logic end_row;
        logic found_v;

        state_next     = state_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        i_next         = i_reg;
        round_next     = round_reg;
        reached_next   = reached_reg;
        low_next       = low_reg;
        found_next     = found_reg;
        ds_next        = ds_reg;
        dist_we        = 1'b0;
        dist_waddr     = e_reg;
        dist_wdata     = cand_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_index_next = out_index_reg;
        out_dist_next  = out_dist_reg;
        out_reach_next = out_reach_reg;
        out_cycle_next = out_cycle_reg;
        out_last_next  = out_last_reg;
        improve        = 1'b0;
        end_row        = 1'b0;
        found_v        = found_reg;

        unique case (state_reg)
            S_CLR:
            begin
                if (!edge_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_RUN:   state_next = S_INIT;
                        REQ_CLEAR: state_next = S_CLR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT:
            begin
                dist_we      = 1'b1;
                dist_waddr   = '0;
                dist_wdata   = '0;
                reached_next = {{(MAX_NODES-1){1'b0}}, 1'b1};
                s_next       = '0;
                e_next       = '0;
                round_next   = '0;
                low_next     = 1'b0;
                found_next   = 1'b0;
                state_next   = S_ROW;
            end
            S_ROW:
            begin
                if (reached_reg[s_reg])
                begin
                    state_next = S_ROWLD;
                end
                else
                begin
                    end_row = 1'b1;
                end
            end
            S_ROWLD:
            begin
                ds_next    = dist_rdata;
                e_next     = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (edge_present && sum_now.low)
                begin
                    low_next = 1'b1;
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                improve = pres_reg && (!reached_reg[e_reg] || (cand_reg < de_reg));
                if (improve)
                begin
                    if (round_reg == n_eff)
                    begin
                        found_v    = 1'b1;
                        found_next = 1'b1;
                    end
                    else
                    begin
                        dist_we             = 1'b1;
                        reached_next[e_reg] = 1'b1;
                        if (e_reg == s_reg)
                        begin
                            ds_next = cand_reg;
                        end
                    end
                end
                if (e_reg == n_last)
                begin
                    end_row = 1'b1;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FLAG:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = '0;
                    out_dist_next  = '0;
                    out_reach_next = 1'b0;
                    out_cycle_next = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = i_reg;
                    out_dist_next  = reached_reg[i_reg] ? $signed(dist_rdata) : '0;
                    out_reach_next = reached_reg[i_reg];
                    out_cycle_next = 1'b0;
                    out_last_next  = (i_reg == n_last);
                    if (i_reg == n_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a row: next row, next pass, or finish the run
        if (end_row)
        begin
            if (s_reg == n_last)
            begin
                s_next = '0;
                if (round_reg == n_eff)
                begin
                    i_next = NODE_W'(1);
                    if (found_v || low_next)
                    begin
                        state_next = S_FLAG;
                    end
                    else if (n_eff == NCOUNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                    state_next = S_ROW;
                end
            end
            else
            begin
                s_next     = s_reg + 1'b1;
                state_next = S_ROW;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            ncount_reg    <= NCOUNT_W'(MAX_NODES);
            s_reg         <= '0;
            e_reg         <= '0;
            i_reg         <= '0;
            round_reg     <= '0;
            reached_reg   <= '0;
            low_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                ncount_reg <= cfg_wdata;
            end
            s_reg         <= s_next;
            e_reg         <= e_next;
            i_reg         <= i_next;
            round_reg     <= round_next;
            reached_reg   <= reached_next;
            low_reg       <= low_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result word
    always_ff @(posedge clk)
    begin
        ds_reg        <= ds_next;
        de_reg        <= dist_rdata;
        cand_reg      <= sum_now.value;
        pres_reg      <= edge_present;
        out_index_reg <= out_index_next;
        out_dist_reg  <= out_dist_next;
        out_reach_reg <= out_reach_next;
        out_cycle_reg <= out_cycle_next;
        out_last_reg  <= out_last_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.node_index     = out_index_reg;
    assign res.distance       = out_dist_reg;
    assign res.reachable      = out_reach_reg;
    assign res.negative_cycle = out_cycle_reg;
    assign res.last           = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/bfsp_checker.sv -----
// ----------------------------------------------------------------------------
// bfsp_port_checker
// port level checks on the shortest path block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bellman_ford_shortest_paths_macros.svh"

module bfsp_port_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic [1:0]                    req_type,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [bfsp_pkg::DIST_W-1:0]   res_distance,
    input wire logic                          res_reachable,
    input wire logic                          res_negative_cycle,
    input wire logic                          res_last
);
    import bfsp_pkg::*;

    // a stalled word holds
    `BFSP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_distance))

    // a cycle word is the lone, last word of a run and carries no distance
    `BFSP_ASSERT_SAME(a_cycle_alone, res_valid && res_negative_cycle,
                      res_last && !res_reachable && (res_distance == '0))

    // no new request while a run still has words to deliver
    `BFSP_ASSERT_SAME(a_run_busy, res_valid && !res_last, !req_ready)

    // a run request closes the request side on the next cycle
    `BFSP_ASSERT_NEXT(a_run_blocks, req_valid && req_ready && (req_type == REQ_RUN), !req_ready)

endmodule

bind bellman_ford_shortest_paths bfsp_port_checker u_bfsp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_type           (req.req_type),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_distance       (res.distance),
    .res_reachable      (res.reachable),
    .res_negative_cycle (res.negative_cycle),
    .res_last           (res.last)
);

`default_nettype wire

// ----- tb/bfsp_checker.sv -----
// ----------------------------------------------------------------------------
// bfsp_checker
// watches the request, result and register ports of the shortest path block,
// keeps its own copy of the edge matrix and node count, works out the
// distance words each run should give and compares them field by field
// ----------------------------------------------------------------------------
module bfsp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    bfsp_req_if                           req,
    bfsp_res_if                           res,
    input  logic                          cfg_we,
    input  logic [bfsp_pkg::NCOUNT_W-1:0] cfg_wdata,
    output int                            fail_count,
    output int                            words_pending,
    output int                            runs_seen,
    output int                            dist_words_seen,
    output int                            cycle_words_seen
);
    import bfsp_pkg::*;

    localparam longint DIST_HI = (longint'(1) << (DIST_W - 1)) - 1;
    localparam longint DIST_LO = -DIST_HI - 1;

    typedef struct packed {
        logic [NODE_W-1:0]        node_index;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic                     negative_cycle;
        logic                     last;
    } dist_word_t;

    // private copy of the graph and of the last run
    bit                  edge_on       [MAX_NODES*MAX_NODES];
    int                  edge_cost_tab [MAX_NODES*MAX_NODES];
    longint              dist_tab      [MAX_NODES];
    bit                  reached_tab   [MAX_NODES];
    logic [NCOUNT_W-1:0] node_count_q;
    dist_word_t          pending_dist_words [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // saturating sum, flags a clip at the lower bound
    function automatic longint clip_add(input longint d, input longint w, inout bit hit_floor);
        if (w > 0 && d > DIST_HI - w)
            return DIST_HI;
        if (w < 0 && d < DIST_LO - w)
        begin
            hit_floor = 1'b1;
            return DIST_LO;
        end
        return d + w;
    endfunction

    // one sweep over all present edges out of reached nodes, or a check for any improvement when not committing
    function automatic bit relax_all(input int n, input bit commit, inout bit hit_floor);
        bit     improved;
        longint cand;
        int     k;
        improved = 1'b0;
        for (int s = 0; s < n; s++)
        begin
            if (!reached_tab[s])
                continue;
            for (int e = 0; e < n; e++)
            begin
                k = s * MAX_NODES + e;
                if (!edge_on[k])
                    continue;
                cand = clip_add(dist_tab[s], longint'(edge_cost_tab[k]), hit_floor);
                if (!reached_tab[e] || cand < dist_tab[e])
                begin
                    if (!commit)
                        return 1'b1;
                    improved       = 1'b1;
                    dist_tab[e]    = cand;
                    reached_tab[e] = 1'b1;
                end
            end
        end
        return improved;
    endfunction

    // shortest paths from node zero, queues the words the run should give
    function automatic void predict_shortest_paths();
        int         n;
        bit         hit_floor;
        bit         still_improving;
        dist_word_t w;
        n = int'(node_count_q);
        if (n < 1)
            n = 1;
        if (n > MAX_NODES)
            n = MAX_NODES;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            reached_tab[i] = 1'b0;
            dist_tab[i]    = 0;
        end
        reached_tab[0] = 1'b1;
        hit_floor      = 1'b0;
        for (int r = 0; r < n; r++)
            void'(relax_all(n, 1'b1, hit_floor));
        still_improving = relax_all(n, 1'b0, hit_floor);
        if (still_improving || hit_floor)
        begin
            w                = '0;
            w.negative_cycle = 1'b1;
            w.last           = 1'b1;
            pending_dist_words.push_back(w);
            return;
        end
        for (int i = 1; i < n; i++)
        begin
            w                = '0;
            w.node_index     = NODE_W'(i);
            w.distance       = reached_tab[i] ? dist_tab[i][DIST_W-1:0] : '0;
            w.reachable      = reached_tab[i];
            w.last           = (i == n - 1);
            pending_dist_words.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        dist_word_t want;
        int         k;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES * MAX_NODES; i++)
            begin
                edge_on[i]       = 1'b0;
                edge_cost_tab[i] = 0;
            end
            for (int i = 0; i < MAX_NODES; i++)
            begin
                dist_tab[i]    = 0;
                reached_tab[i] = 1'b0;
            end
            node_count_q = NCOUNT_W'(MAX_NODES);
            pending_dist_words.delete();
        end
        else
        begin
            // register write
            if (cfg_we)
                node_count_q = cfg_wdata;

            // request word
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_ADD)
                begin
                    k = int'(req.src_node) * MAX_NODES + int'(req.dst_node);
                    if (!edge_on[k] || int'(req.edge_cost) < edge_cost_tab[k])
                    begin
                        edge_cost_tab[k] = int'(req.edge_cost);
                        edge_on[k]       = 1'b1;
                    end
                end
                else if (req.req_type == REQ_CLEAR)
                begin
                    for (int i = 0; i < MAX_NODES * MAX_NODES; i++)
                        edge_on[i] = 1'b0;
                end
                else if (req.req_type == REQ_RUN)
                begin
                    runs_seen++;
                    predict_shortest_paths();
                end
            end

            // result word against the oldest expectation
            if (res.valid && res.ready)
            begin
                if (pending_dist_words.size() == 0)
                    report_mismatch("unexpected result word, node_index", res.node_index, -1);
                else
                begin
                    want = pending_dist_words.pop_front();
                    if (want.negative_cycle)
                        cycle_words_seen++;
                    else
                        dist_words_seen++;
                    if (res.node_index !== want.node_index)
                        report_mismatch("node_index", res.node_index, want.node_index);
                    if (res.distance !== want.distance)
                        report_mismatch("distance", longint'(res.distance),
                                        longint'(want.distance));
                    if (res.reachable !== want.reachable)
                        report_mismatch("reachable", res.reachable, want.reachable);
                    if (res.negative_cycle !== want.negative_cycle)
                        report_mismatch("negative_cycle", res.negative_cycle,
                                        want.negative_cycle);
                    if (res.last !== want.last)
                        report_mismatch("last", res.last, want.last);
                end
            end
        end
        words_pending = pending_dist_words.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives edge, run and clear requests into the shortest path block under
// several node counts and idling patterns, including one long result stall,
// and gives the verdict from the checker's failure count and pending words
// ----------------------------------------------------------------------------
module tb_top;
    import bfsp_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS   = 480;
    localparam int         RANDOM_PHASES  = 8;
    localparam int         SETTLE_CYCLES  = 4300;     // clear sweep plus margin
    localparam int         RX_HOLD_CYCLES = 3000;
    localparam int         WATCHDOG_LIMIT = 200000;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [NCOUNT_W-1:0] cfg_wdata;
    idle_mode_e          idle_mode;
    bit                  rx_hold;
    bit                  pressure_armed;
    int                  items_sent;
    int                  fail_count;
    int                  words_pending;
    int                  runs_seen;
    int                  dist_words_seen;
    int                  cycle_words_seen;

    bfsp_req_if req_ch ();
    bfsp_res_if res_ch ();

    bellman_ford_shortest_paths DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bfsp_checker path_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req_ch),
        .res              (res_ch),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .words_pending    (words_pending),
        .runs_seen        (runs_seen),
        .dist_words_seen  (dist_words_seen),
        .cycle_words_seen (cycle_words_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit tx_gap();
        case (idle_mode)
            IDLE_TX:   return $urandom_range(99) < 65;
            IDLE_BOTH: return $urandom_range(99) < 27;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit rx_stall();
        case (idle_mode)
            IDLE_RX:   return $urandom_range(99) < 65;
            IDLE_BOTH: return $urandom_range(99) < 27;
            default:   return 1'b0;
        endcase
    endfunction

    // mostly modest positive costs, some small negatives, a few anywhere
    function automatic int pick_cost();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return int'($urandom_range(2000));
        if (sel < 87)
            return -int'($urandom_range(60, 1));
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // result side: random stalls, or one long hold-off when asked
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
            end
            else
                res_ch.ready <= !rx_stall();
        end
    end

    // watchdog on cycles with no word moving either way
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one request word, entered and left at a falling edge
    task automatic send_word(input logic [1:0] kind, input int s, input int d, input int c);
        while (tx_gap())
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.src_node  <= s[NODE_W-1:0];
        req_ch.dst_node  <= d[NODE_W-1:0];
        req_ch.edge_cost <= c[COST_W-1:0];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (kind != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_run();
        send_word(REQ_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
        if (pressure_armed)
        begin
            pressure_armed = 1'b0;
            rx_hold        = 1'b1;
        end
    endtask

    task automatic send_clear();
        send_word(REQ_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
    endtask

    // drain every expected word, then let a clear or a silent run finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_nodes(input int count);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= count[NCOUNT_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // optional clear, one to 2n words (edges, mostly among the live nodes, and some unknown requests), then a run
    task automatic send_sequence(input int n);
        int edges;
        if ($urandom_range(2) == 0)
            send_clear();
        edges = $urandom_range(2 * n, 1);
        repeat (edges)
        begin
            case ($urandom_range(19))
                0:       send_word(REQ_UNUSED, $urandom_range(63), $urandom_range(63),
                                   $urandom_range(65535));
                1, 2:    send_word(REQ_ADD, $urandom_range(63), $urandom_range(63),
                                   pick_cost());
                default: send_word(REQ_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                                   pick_cost());
            endcase
        end
        send_run();
    endtask

    // stimulus
    initial
    begin : stimulus
        int target;
        int n;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_ADD;
        req_ch.src_node  = '0;
        req_ch.dst_node  = '0;
        req_ch.edge_cost = '0;
        idle_mode        = IDLE_NONE;
        rx_hold          = 1'b0;
        pressure_armed   = 1'b0;
        items_sent       = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // four nodes: extreme costs, repeated pair keeps the cheaper cost,
        // edges past the live nodes, unknown request
        set_nodes(4);
        send_word(REQ_ADD, 0, 1, 32767);
        send_word(REQ_ADD, 1, 2, -32768);
        send_word(REQ_ADD, 0, 1, 100);
        send_word(REQ_ADD, 0, 1, 200);
        send_word(REQ_ADD, 2, 3, 5);
        send_word(REQ_ADD, 3, 10, 1);
        send_word(REQ_ADD, 63, 63, -32768);
        send_word(REQ_UNUSED, 63, 63, 65535);
        send_run();
        // closing a negative loop, then an empty graph
        send_word(REQ_ADD, 3, 1, 0);
        send_run();
        send_clear();
        send_run();

        // single node: negative self loop, then nothing at all
        set_nodes(1);
        send_word(REQ_ADD, 0, 0, -1);
        send_run();
        send_clear();
        send_run();

        // zero acts as one node
        set_nodes(0);
        send_word(REQ_ADD, 0, 0, 0);
        send_run();

        // full size, and a count above the node limit
        set_nodes(MAX_NODES);
        send_clear();
        send_word(REQ_ADD, 0, 63, 32767);
        send_word(REQ_ADD, 63, 62, -32768);
        send_run();
        set_nodes(127);
        send_run();
        send_clear();

        // random phases with small graphs under each idling pattern
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            n = $urandom_range(9, 2);
            set_nodes(n);
            idle_mode      = idle_mode_e'(p % 4);
            pressure_armed = (p == 0);
            target         = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < target)
                send_sequence(n);
        end

        settle();
        $display("sent %0d request words: %0d runs gave %0d distance words and %0d cycle flags",
                 items_sent, runs_seen, dist_words_seen, cycle_words_seen);
        $display("node counts 0, 1, 4, 64, 127 and small random sizes, four idling patterns");
        if (words_pending != 0)
            $display("%0d expected result words never arrived", words_pending);
        if (fail_count == 0 && words_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
